// ===== rtl/lsu_pkg.sv =====
// ----------------------------------------------------------------------------
// lsu_pkg
// Shared widths, mode codes and stage types of the limited slope unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lsu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIFF_WIDTH = DATA_WIDTH + 1;
    localparam int MAG_WIDTH  = DATA_WIDTH;
    localparam int PROD_WIDTH = 2 * MAG_WIDTH;
    localparam int HALF_WIDTH = MAG_WIDTH / 2;
    localparam int SUM_WIDTH  = MAG_WIDTH + 1;
    localparam int DIV_STEPS  = PROD_WIDTH;
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES = DIV_STEPS / STEPS_PER_STAGE;

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_VL   = 2'd1;
    localparam logic [1:0] MODE_MC   = 2'd2;
    localparam logic [1:0] MODE_RESET = MODE_MC;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value_left;
        logic [DATA_WIDTH-1:0] value_center;
        logic [DATA_WIDTH-1:0] value_right;
        logic [DATA_WIDTH-1:0] scale_minus;
        logic [DATA_WIDTH-1:0] scale_plus;
        logic [DATA_WIDTH-1:0] scale_central;
    } lsu_in_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] half_slope;
        logic                  saturated;
    } lsu_out_t;

    // signed scaled difference held as sign and magnitude
    typedef struct packed {
        logic                 neg;
        logic [MAG_WIDTH-1:0] mag;
    } lsu_sm_t;

endpackage

`default_nettype wire

// ===== rtl/lsu_if.sv =====
// ----------------------------------------------------------------------------
// lsu_in_if / lsu_out_if
// Valid/ready channels of the limited slope unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsu_in_if import lsu_pkg::*;;
    logic    valid;
    logic    ready;
    lsu_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lsu_out_if import lsu_pkg::*;;
    logic     valid;
    logic     ready;
    lsu_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/limited_slope_unit_top.sv =====
// ----------------------------------------------------------------------------
// limited_slope_unit_top
// Pipelined slope limiter: scaled differences, then van Leer, MC minmod or zero.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries three cell values and three scale factors per transfer;
//   out_ch returns the limited half slope and a clip flag per transfer.
//   limiter_mode_we/limiter_mode_data load the 2-bit limiter mode; write it
//   only while no item is in flight.
// Throughput: one item per cycle while out_ch is ready. Pipeline: 22 register
//   stages from in_ch to out_ch (5 stages of difference and multiply, 16 stages
//   of restoring division at four quotient bits each, 1 stage of select and
//   output register); the van Leer divider sets the depth.
// Reset: all stage valid bits clear, the mode returns to monotonized central.
// Stall: when out_ch is not ready, the whole pipeline holds; in_ch.ready
//   is high whenever the last stage is empty or is being taken, so no item
//   is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module limited_slope_unit_top
    import lsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       limiter_mode_we,
    input  wire logic [1:0] limiter_mode_data,
    lsu_in_if.sink          in_ch,
    lsu_out_if.source       out_ch
);

    localparam int NSTG = 6 + DIV_STAGES;

    logic [1:0]       mode_reg;
    logic [NSTG-1:0]  vld_reg;
    logic             adv;

    assign adv          = !vld_reg[NSTG-1] || out_ch.ready;
    assign in_ch.ready  = adv;
    assign out_ch.valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            vld_reg  <= '0;
        end
        else
        begin
            if (limiter_mode_we)
                mode_reg <= limiter_mode_data;
            if (adv)
                vld_reg <= {vld_reg[NSTG-2:0], in_ch.valid};
        end
    end

    // stage 1: exact differences as sign and magnitude
    logic                  s1_neg_m_reg, s1_neg_p_reg, s1_neg_c_reg;
    logic [DATA_WIDTH-1:0] s1_mag_m_reg, s1_mag_p_reg, s1_mag_c_reg;
    logic [DATA_WIDTH-1:0] s1_sc_m_reg, s1_sc_p_reg, s1_sc_c_reg;
    logic signed [DIFF_WIDTH-1:0] d_m, d_p, d_c;
    logic [DIFF_WIDTH-1:0] a_m, a_p, a_c;

    always_comb
    begin
        d_m = $signed({in_ch.data.value_center[DATA_WIDTH-1], in_ch.data.value_center})
            - $signed({in_ch.data.value_left[DATA_WIDTH-1], in_ch.data.value_left});
        d_p = $signed({in_ch.data.value_right[DATA_WIDTH-1], in_ch.data.value_right})
            - $signed({in_ch.data.value_center[DATA_WIDTH-1], in_ch.data.value_center});
        d_c = $signed({in_ch.data.value_right[DATA_WIDTH-1], in_ch.data.value_right})
            - $signed({in_ch.data.value_left[DATA_WIDTH-1], in_ch.data.value_left});
        a_m = d_m[DIFF_WIDTH-1] ? -d_m : d_m;
        a_p = d_p[DIFF_WIDTH-1] ? -d_p : d_p;
        a_c = d_c[DIFF_WIDTH-1] ? -d_c : d_c;
    end

    // magnitude of a 33-bit difference fits 32 bits (max 2^32-1)
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_neg_m_reg <= d_m[DIFF_WIDTH-1];
            s1_neg_p_reg <= d_p[DIFF_WIDTH-1];
            s1_neg_c_reg <= d_c[DIFF_WIDTH-1];
            s1_mag_m_reg <= a_m[DATA_WIDTH-1:0];
            s1_mag_p_reg <= a_p[DATA_WIDTH-1:0];
            s1_mag_c_reg <= a_c[DATA_WIDTH-1:0];
            s1_sc_m_reg  <= in_ch.data.scale_minus;
            s1_sc_p_reg  <= in_ch.data.scale_plus;
            s1_sc_c_reg  <= in_ch.data.scale_central;
        end
    end

    // stage 2: 16x16 partial products; stage 3: sum and scale, saturate
    logic [DATA_WIDTH-1:0] s2_pp_reg [3][4];
    logic                  s2_neg_reg [3];
    logic [DATA_WIDTH-1:0] mg [3];
    logic [DATA_WIDTH-1:0] sc [3];

    always_comb
    begin
        mg[0] = s1_mag_m_reg; mg[1] = s1_mag_p_reg; mg[2] = s1_mag_c_reg;
        sc[0] = s1_sc_m_reg;  sc[1] = s1_sc_p_reg;  sc[2] = s1_sc_c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_pp_reg[k][0] <= mg[k][HALF_WIDTH-1:0] * sc[k][HALF_WIDTH-1:0];
                s2_pp_reg[k][1] <= mg[k][HALF_WIDTH-1:0] * sc[k][MAG_WIDTH-1:HALF_WIDTH];
                s2_pp_reg[k][2] <= mg[k][MAG_WIDTH-1:HALF_WIDTH] * sc[k][HALF_WIDTH-1:0];
                s2_pp_reg[k][3] <= mg[k][MAG_WIDTH-1:HALF_WIDTH] * sc[k][MAG_WIDTH-1:HALF_WIDTH];
            end
            s2_neg_reg[0] <= s1_neg_m_reg;
            s2_neg_reg[1] <= s1_neg_p_reg;
            s2_neg_reg[2] <= s1_neg_c_reg;
        end
    end

    lsu_sm_t               s3_sd_reg [3];
    logic                  s3_clip_reg;
    logic [PROD_WIDTH-1:0] prod [3];
    logic [PROD_WIDTH-1:0] shf [3];
    lsu_sm_t               sd_next [3];
    logic [2:0]            clip_k;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod[k] = {{DATA_WIDTH{1'b0}}, s2_pp_reg[k][0]}
                    + ({{DATA_WIDTH{1'b0}}, s2_pp_reg[k][1]} << HALF_WIDTH)
                    + ({{DATA_WIDTH{1'b0}}, s2_pp_reg[k][2]} << HALF_WIDTH)
                    + ({{DATA_WIDTH{1'b0}}, s2_pp_reg[k][3]} << MAG_WIDTH);
            shf[k] = prod[k] >> FRAC_BITS;
            sd_next[k].neg = s2_neg_reg[k];
            clip_k[k] = 1'b0;
            if (shf[k][PROD_WIDTH-1:DATA_WIDTH-1] != '0)
            begin
                if (s2_neg_reg[k] && shf[k] == (PROD_WIDTH'(1) << (DATA_WIDTH-1)))
                    clip_k[k] = 1'b0;
                else
                    clip_k[k] = 1'b1;
            end
            if (clip_k[k])
                sd_next[k].mag = s2_neg_reg[k] ? (MAG_WIDTH'(1) << (DATA_WIDTH-1))
                                               : {1'b0, {(MAG_WIDTH-1){1'b1}}};
            else
                sd_next[k].mag = shf[k][MAG_WIDTH-1:0];
            if (sd_next[k].mag == '0)
                sd_next[k].neg = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
                s3_sd_reg[k] <= sd_next[k];
            s3_clip_reg <= |clip_k;
        end
    end

    // stage 4: van Leer product partials, MC minmod result
    logic [DATA_WIDTH-1:0] s4_pp_reg [4];
    logic [SUM_WIDTH-1:0]  s4_den_reg;
    logic                  s4_vl_ok_reg, s4_neg_reg, s4_clip_reg;
    logic [DATA_WIDTH-1:0] s4_mc_reg;
    logic [1:0]            s4_mode_reg;
    lsu_sm_t               mm_in, mm_out;
    logic                  mc_ok;
    logic [DATA_WIDTH-1:0] mc_half;

    always_comb
    begin
        lsu_sm_t dm, dp, dc;
        dm = s3_sd_reg[0]; dp = s3_sd_reg[1]; dc = s3_sd_reg[2];
        // minmod(2dm,2dp): comparing doubled magnitudes equals comparing plain
        mm_in.neg = dm.neg;
        if (dm.mag == '0 || dp.mag == '0 || dm.neg != dp.neg)
            mm_in.mag = '0;
        else if (dm.mag < dp.mag)
            mm_in.mag = dm.mag;
        else
        begin
            mm_in.mag = dp.mag;
            mm_in.neg = dp.neg;
        end
        // inner value is 2*mm_in; compare against dc
        mm_out.neg = dc.neg;
        mm_out.mag = '0;
        mc_ok = (mm_in.mag != '0) && (dc.mag != '0) && (dc.neg == mm_in.neg);
        if ({1'b0, dc.mag} < {mm_in.mag, 1'b0})
            mc_half = {1'b0, dc.mag[MAG_WIDTH-1:1]};
        else
            mc_half = mm_in.mag;
        mm_out.mag = mc_ok ? mc_half : '0;
        if (mm_out.neg)
            mm_out.mag = -mm_out.mag;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_pp_reg[0] <= s3_sd_reg[0].mag[HALF_WIDTH-1:0]
                          * s3_sd_reg[1].mag[HALF_WIDTH-1:0];
            s4_pp_reg[1] <= s3_sd_reg[0].mag[HALF_WIDTH-1:0]
                          * s3_sd_reg[1].mag[MAG_WIDTH-1:HALF_WIDTH];
            s4_pp_reg[2] <= s3_sd_reg[0].mag[MAG_WIDTH-1:HALF_WIDTH]
                          * s3_sd_reg[1].mag[HALF_WIDTH-1:0];
            s4_pp_reg[3] <= s3_sd_reg[0].mag[MAG_WIDTH-1:HALF_WIDTH]
                          * s3_sd_reg[1].mag[MAG_WIDTH-1:HALF_WIDTH];
            s4_den_reg   <= {1'b0, s3_sd_reg[0].mag} + {1'b0, s3_sd_reg[1].mag};
            s4_vl_ok_reg <= (s3_sd_reg[0].mag != '0) && (s3_sd_reg[1].mag != '0)
                          && (s3_sd_reg[0].neg == s3_sd_reg[1].neg);
            s4_neg_reg   <= s3_sd_reg[0].neg;
            s4_clip_reg  <= s3_clip_reg;
            s4_mc_reg    <= mm_out.mag;
            s4_mode_reg  <= mode_reg;
        end
    end

    // stage 5: full product and divisor (1 where van Leer does not apply)
    logic [PROD_WIDTH-1:0] s5_num_reg;
    logic [SUM_WIDTH-1:0]  s5_den_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_num_reg <= {{DATA_WIDTH{1'b0}}, s4_pp_reg[0]}
                        + ({{DATA_WIDTH{1'b0}}, s4_pp_reg[1]} << HALF_WIDTH)
                        + ({{DATA_WIDTH{1'b0}}, s4_pp_reg[2]} << HALF_WIDTH)
                        + ({{DATA_WIDTH{1'b0}}, s4_pp_reg[3]} << MAG_WIDTH);
            s5_den_reg <= s4_vl_ok_reg ? s4_den_reg : SUM_WIDTH'(1);
        end
    end

    // side band carried alongside the divider
    typedef struct packed {
        logic                  vl_ok;
        logic                  neg;
        logic                  clip;
        logic [DATA_WIDTH-1:0] mc;
        logic [1:0]            mode;
    } side_t;

    side_t s5_side_reg;
    side_t side_reg [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_side_reg <= '{vl_ok: s4_vl_ok_reg, neg: s4_neg_reg, clip: s4_clip_reg,
                             mc: s4_mc_reg, mode: s4_mode_reg};
            side_reg[0] <= s5_side_reg;
            for (int j = 1; j < DIV_STAGES; j++)
                side_reg[j] <= side_reg[j-1];
        end
    end

    logic [PROD_WIDTH-1:0] dnum [DIV_STAGES+1];
    logic [SUM_WIDTH-1:0]  drem [DIV_STAGES+1];
    logic [SUM_WIDTH-1:0]  dden [DIV_STAGES+1];
    logic [PROD_WIDTH-1:0] dquo [DIV_STAGES+1];

    assign dnum[0] = s5_num_reg;
    assign drem[0] = '0;
    assign dden[0] = s5_den_reg;
    assign dquo[0] = '0;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        lsu_div_stage u_stage (
            .clk     (clk),
            .en      (adv),
            .num_in  (dnum[g]),
            .rem_in  (drem[g]),
            .den_in  (dden[g]),
            .quo_in  (dquo[g]),
            .num_out (dnum[g+1]),
            .rem_out (drem[g+1]),
            .den_out (dden[g+1]),
            .quo_out (dquo[g+1])
        );
    end

    // final stage: select and register the result
    lsu_out_t out_reg;
    lsu_out_t out_next;
    side_t    sl;
    logic [DATA_WIDTH-1:0] vl_q;

    always_comb
    begin
        sl   = side_reg[DIV_STAGES-1];
        vl_q = dquo[DIV_STAGES][DATA_WIDTH-1:0];
        out_next.saturated = sl.clip;
        case (sl.mode)
            MODE_VL:
                out_next.half_slope = !sl.vl_ok ? '0 : (sl.neg ? -vl_q : vl_q);
            MODE_MC:
                out_next.half_slope = sl.mc;
            default:
                out_next.half_slope = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_ch.data = out_reg;

    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data);
    endproperty
    a_stall_hold: assert property (p_stall_hold) else $error("output changed under stall");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!out_ch.valid || out_ch.ready))
        else $error("ready mismatch");

    a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && $past(adv) && $past(sl.mode) == MODE_ZERO
        |-> out_ch.data.half_slope == '0)
        else $error("donor cell slope nonzero");

endmodule

`default_nettype wire

// ===== rtl/lsu_div_stage.sv =====
// ----------------------------------------------------------------------------
// lsu_div_stage
// Four restoring division steps of the van Leer quotient, one register deep.
// ----------------------------------------------------------------------------
`default_nettype none

module lsu_div_stage
    import lsu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [PROD_WIDTH-1:0] num_in,
    input  wire logic [SUM_WIDTH-1:0]  rem_in,
    input  wire logic [SUM_WIDTH-1:0]  den_in,
    input  wire logic [PROD_WIDTH-1:0] quo_in,
    output logic      [PROD_WIDTH-1:0] num_out,
    output logic      [SUM_WIDTH-1:0]  rem_out,
    output logic      [SUM_WIDTH-1:0]  den_out,
    output logic      [PROD_WIDTH-1:0] quo_out
);

    logic [PROD_WIDTH-1:0] num_next;
    logic [SUM_WIDTH-1:0]  rem_next;
    logic [PROD_WIDTH-1:0] quo_next;
    logic [SUM_WIDTH:0]    trial;

    always_comb
    begin
        num_next = num_in;
        rem_next = rem_in;
        quo_next = quo_in;
        trial    = '0;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            trial    = {rem_next, num_next[PROD_WIDTH-1]};
            num_next = {num_next[PROD_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, den_in})
            begin
                trial    = trial - {1'b0, den_in};
                quo_next = {quo_next[PROD_WIDTH-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_next[PROD_WIDTH-2:0], 1'b0};
            end
            rem_next = trial[SUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_out <= num_next;
            rem_out <= rem_next;
            den_out <= den_in;
            quo_out <= quo_next;
        end
    end

endmodule

`default_nettype wire
